>>> hw/rtl/wildcard_byte_pattern_scanner_unit_assert.svh
// Assertion macros for the wildcard byte pattern scanner.
// Used by the top level; no other dependencies.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication
`define WBPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wbps: implication violated");

// next-cycle implication
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wbps: next-cycle implication violated");

`endif

>>> hw/rtl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wbps_pkg;

   localparam int WBPS_MAX_PATTERN = 16;
   localparam int WBPS_OFFSET_BITS = 32;

   localparam int BYTE_W      = 8;
   localparam int ADDR_W      = 32;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int PAT_POS     = 16;   // pattern positions with stored bytes
   localparam int PAT_IDX_W   = 4;
   localparam int PLEN_W      = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REGION_BASE    = 3'd0,
      CSR_PATTERN_LOW    = 3'd1,
      CSR_PATTERN_HIGH   = 3'd2,
      CSR_CARE_MASK      = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]                 region_base;
      logic [PAT_POS-1:0][BYTE_W-1:0]    pattern;
      logic [PAT_POS-1:0]                care_mask;
      logic [PLEN_W-1:0]                 pattern_length;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              region_end;
   } item_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_type;

endpackage

>>> hw/rtl/wbps_csr.sv
// Configuration registers of the pattern scanner.
// Depends on wbps_pkg.
`timescale 1ns / 1ps

module wbps_csr
   import wbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_REGION_BASE:    cfg_in.region_base = csr_wdata[ADDR_W-1:0];
            CSR_PATTERN_LOW:    cfg_in.pattern[7:0] = csr_wdata;
            CSR_PATTERN_HIGH:   cfg_in.pattern[15:8] = csr_wdata;
            CSR_CARE_MASK:      cfg_in.care_mask = csr_wdata[PAT_POS-1:0];
            CSR_PATTERN_LENGTH: cfg_in.pattern_length = csr_wdata[PLEN_W-1:0];
            default:            cfg_in = cfg_ff;   // unknown index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                <= '0;
         cfg_ff.pattern_length <= PLEN_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/wbps_scan.sv
// Scan stage: sliding byte window, fill and offset counters, masked compare.
// Depends on wbps_pkg; driven by the top level input register.
`timescale 1ns / 1ps

module wbps_scan
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN = WBPS_MAX_PATTERN,
   parameter int OFFSET_BITS = WBPS_OFFSET_BITS
)
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     item_valid,
   input  item_type item,
   output logic     res_valid,
   output rsp_type  res
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_ff, window_in;
   logic [LEN_W-1:0]                   fill_ff, fill_in;
   logic [OFFSET_BITS-1:0]             seen_ff, seen_in;
   logic                               reported_ff, reported_in;

   logic [LEN_W-1:0]       len;
   logic                   match;
   logic                   hit;
   logic [OFFSET_BITS-1:0] offset;
   logic [ADDR_W-1:0]      address;

   // length 0 counts as 1, lengths past the window clamp to it
   always_comb begin
      if (cfg.pattern_length == '0) begin
         len = LEN_W'(1);
      end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
         len = LEN_W'(MAX_PATTERN);
      end else begin
         len = LEN_W'(cfg.pattern_length);
      end
   end

   // newest byte at position 0
   always_comb begin
      window_in[0] = item.data_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   assign fill_in = (fill_ff == LEN_W'(MAX_PATTERN)) ? fill_ff : fill_ff + LEN_W'(1);
   assign seen_in = seen_ff + OFFSET_BITS'(1);

   // window slot k holds pattern position len-1-k; positions past 15 are wildcards
   always_comb begin
      int pos;
      pos   = 0;
      match = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pos = int'(len) - 1 - k;
         if (pos >= 0 && pos < PAT_POS) begin
            if (cfg.care_mask[pos[PAT_IDX_W-1:0]] &&
                window_in[k] != cfg.pattern[pos[PAT_IDX_W-1:0]]) begin
               match = 1'b0;
            end
         end
      end
   end

   assign hit     = !reported_ff && (fill_in >= len) && match;
   assign offset  = seen_in - OFFSET_BITS'(len);
   assign address = cfg.region_base + ADDR_W'(offset);

   assign res_valid         = item_valid && (hit || (item.region_end && !reported_ff));
   assign res.found         = hit;
   assign res.match_address = hit ? address : '0;

   always_comb begin
      if (item.region_end) begin
         reported_in = 1'b0;
      end else begin
         reported_in = reported_ff | hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (item_valid) begin
         fill_ff     <= item.region_end ? '0 : fill_in;
         seen_ff     <= item.region_end ? '0 : seen_in;
         reported_ff <= reported_in;
      end
   end

   // stale bytes are never compared: fill gates every slot in use
   always_ff @(posedge clock) begin
      if (item_valid) begin
         window_ff <= window_in;
      end
   end

endmodule

>>> hw/rtl/wildcard_byte_pattern_scanner_unit.sv
// Wildcard byte pattern scanner, top level.
// A byte goes from the input register through the scan compare; any result loads the result reg.
// Throughput: one byte per cycle unless stalled; the window compare and address add fit one stage.
// An input byte stalls in the input register only while a result is held unread.
// Reset (synchronous, active high) clears the counters and pipeline valids; config resets to length 1.
`timescale 1ns / 1ps

`include "wildcard_byte_pattern_scanner_unit_assert.svh"

module wildcard_byte_pattern_scanner_unit
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN = WBPS_MAX_PATTERN,
   parameter int OFFSET_BITS = WBPS_OFFSET_BITS
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_region_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_found,
   output logic [ADDR_W-1:0]      rsp_match_address,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type  cfg;
   logic     s1_valid_ff, s1_valid_in;
   item_type s1_item_ff;
   logic     s1_adv;
   logic     accept;
   logic     res_valid;
   rsp_type  res;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_ff;

   wbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wbps_scan #(
      .MAX_PATTERN (MAX_PATTERN),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (s1_adv),
      .item       (s1_item_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   // input stage moves on whenever the result register can take a new result
   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.data_byte  <= req_data_byte;
         s1_item_ff.region_end <= req_region_end;
      end
      if (res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = out_ff.found;
   assign rsp_match_address = out_ff.match_address;

   `WBPS_ASSERT_IMPL(a_notfound_zero, clock, reset, out_valid_ff && !out_ff.found, out_ff.match_address == '0)
   `WBPS_ASSERT_IMPL(a_result_on_advance, clock, reset, res_valid, s1_adv)
   `WBPS_ASSERT_NEXT(a_stalled_item_kept, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff)

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench for wildcard_byte_pattern_scanner_unit: directed and random byte regions,
// checked against an in-bench scan model. Depends on wbps_pkg and the scanner RTL.

module tb;
   import wbps_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT   = 400;
   localparam int TOTAL_ITEMS   = 950;
   localparam int CALM_ITEMS    = 150;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic                   req_region_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_found;
   logic [ADDR_W-1:0]      rsp_match_address;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   wildcard_byte_pattern_scanner_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_region_end    (req_region_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   // scan model state
   cfg_type                     cfg_shadow;
   logic [BYTE_W-1:0]           scan_window [WBPS_MAX_PATTERN];
   int unsigned                 window_count;
   logic [WBPS_OFFSET_BITS-1:0] offset_count;
   bit                          region_reported;
   rsp_type                     expected_reports [$];

   int  error_count = 0;
   int  items_sent = 0;
   int  quiet_cycles = 0;
   int  stall_left = 0;
   bit  send_jitter = 1'b0;
   bit  recv_jitter = 1'b0;

   function automatic void clear_scan();
      foreach (scan_window[k]) scan_window[k] = '0;
      window_count = 0;
      offset_count = '0;
      region_reported = 1'b0;
   endfunction

   function automatic int unsigned active_len();
      if (cfg_shadow.pattern_length == 0) return 1;
      if (cfg_shadow.pattern_length > WBPS_MAX_PATTERN) return WBPS_MAX_PATTERN;
      return cfg_shadow.pattern_length;
   endfunction

   task automatic scan_predict(input logic [BYTE_W-1:0] b, input logic is_last);
      int unsigned len;
      bit          hit;
      rsp_type     r;
      len = active_len();
      for (int k = WBPS_MAX_PATTERN - 1; k > 0; k--) scan_window[k] = scan_window[k-1];
      scan_window[0] = b;
      if (window_count < WBPS_MAX_PATTERN) window_count++;
      offset_count++;
      if (!region_reported && window_count >= len) begin
         hit = 1'b1;
         // pattern position i sits len-1-i bytes back from the newest byte
         for (int i = 0; i < len; i++)
            if (cfg_shadow.care_mask[i] && scan_window[len-1-i] != cfg_shadow.pattern[i])
               hit = 1'b0;
         if (hit) begin
            r.found = 1'b1;
            r.match_address = cfg_shadow.region_base + ADDR_W'(offset_count - len);
            expected_reports.push_back(r);
            region_reported = 1'b1;
         end
      end
      if (is_last) begin
         if (!region_reported) begin
            r.found = 1'b0;
            r.match_address = '0;
            expected_reports.push_back(r);
         end
         clear_scan();
      end
   endtask

   // result side: random stall bursts hold rsp_ready low
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (recv_jitter && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected result transfer: found=%0b match_address=%h",
                   rsp_found, rsp_match_address);
            error_count++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0b, actual %0b", want.found, rsp_found);
               error_count++;
            end
            if (rsp_match_address !== want.match_address) begin
               $error("match_address: expected %h, actual %h",
                      want.match_address, rsp_match_address);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (csr_index_type'(idx))
         CSR_REGION_BASE:    cfg_shadow.region_base = value[ADDR_W-1:0];
         CSR_PATTERN_LOW:    cfg_shadow.pattern[PAT_POS/2-1:0] = value;
         CSR_PATTERN_HIGH:   cfg_shadow.pattern[PAT_POS-1:PAT_POS/2] = value;
         CSR_CARE_MASK:      cfg_shadow.care_mask = value[PAT_POS-1:0];
         CSR_PATTERN_LENGTH: cfg_shadow.pattern_length = value[PLEN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // valid stays high from one transfer to the next unless a gap is drawn
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
      if (send_jitter && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_region_end <= is_last;
      do @(posedge clock); while (!(req_valid && req_ready));
      scan_predict(b, is_last);
      items_sent++;
   endtask

   task automatic send_region(input logic [BYTE_W-1:0] bytes_q [$]);
      foreach (bytes_q[k]) send_byte(bytes_q[k], k == bytes_q.size() - 1);
   endtask

   // a byte with no result may still be in the pipe, so settle before config writes
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      // length 1, all wildcard: the first byte matches, the rest are ignored
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_idle();
   endtask

   task automatic test_leading_wildcard();
      put_reg(CSR_REGION_BASE, 64'h0000_1000);
      put_reg(CSR_PATTERN_LOW, 64'h0000_0000_0043_4200);
      put_reg(CSR_CARE_MASK, 64'h6);
      put_reg(CSR_PATTERN_LENGTH, 64'd3);
      send_region('{8'h41, 8'h42, 8'h43});               // match on the last byte
      send_region('{8'h42, 8'h43, 8'h00, 8'h42, 8'h43});
      send_region('{8'h42, 8'h43});                      // shorter than the pattern
      wait_idle();
   endtask

   task automatic test_address_wrap();
      // length 0 acts as 1; base plus offset wraps to zero
      put_reg(CSR_REGION_BASE, 64'hFFFF_FFFF);
      put_reg(CSR_PATTERN_LOW, 64'h5A);
      put_reg(CSR_CARE_MASK, 64'h1);
      put_reg(CSR_PATTERN_LENGTH, 64'd0);
      send_region('{8'h11, 8'h5A, 8'h5A, 8'hFF});
      wait_idle();
   endtask

   task automatic test_length_clamp();
      put_reg(CSR_CARE_MASK, 64'h0);
      put_reg(CSR_PATTERN_LENGTH, 64'd31);
      send_region('{8'h01, 8'h02, 8'h03});
      wait_idle();
   endtask

   task automatic test_unused_index();
      put_reg(CSR_REGION_BASE, 64'h8000_0000);
      put_reg(CSR_PATTERN_LOW, 64'h0);
      put_reg(CSR_CARE_MASK, 64'h1);
      put_reg(CSR_PATTERN_LENGTH, 64'd1);
      for (int idx = CSR_PATTERN_LENGTH + 1; idx < 2**CSR_INDEX_W; idx++)
         put_reg(CSR_INDEX_W'(idx), '1);
      send_region('{8'h00});
      wait_idle();
   endtask

   function automatic logic [CSR_DATA_W-1:0] wide_random();
      return {$urandom, $urandom};
   endfunction

   task automatic random_config();
      logic [CSR_DATA_W-1:0] v;
      v = wide_random();
      case ($urandom_range(0, 5))
         0: v[ADDR_W-1:0] = '0;
         1: v[ADDR_W-1:0] = '1;
         default: ;
      endcase
      put_reg(CSR_REGION_BASE, v);
      put_reg(CSR_PATTERN_LOW, ($urandom_range(0, 7) == 0) ? '1 : wide_random());
      put_reg(CSR_PATTERN_HIGH, ($urandom_range(0, 7) == 0) ? '0 : wide_random());
      v = wide_random();
      case ($urandom_range(0, 4))
         0: v[PAT_POS-1:0] = '0;
         1: v[PAT_POS-1:0] = '1;
         default: ;
      endcase
      put_reg(CSR_CARE_MASK, v);
      v = wide_random();
      case ($urandom_range(0, 9))
         0:    v[PLEN_W-1:0] = 0;
         1:    v[PLEN_W-1:0] = WBPS_MAX_PATTERN;
         2:    v[PLEN_W-1:0] = PLEN_W'($urandom_range(WBPS_MAX_PATTERN + 1, 31));
         3:    v[PLEN_W-1:0] = PLEN_W'($urandom_range(9, WBPS_MAX_PATTERN - 1));
         default: v[PLEN_W-1:0] = PLEN_W'($urandom_range(1, 8));
      endcase
      put_reg(CSR_PATTERN_LENGTH, v);
   endtask

   // half the filler comes from pattern bytes to provoke near misses
   function automatic logic [BYTE_W-1:0] filler_byte();
      if ($urandom_range(0, 1) == 0) return cfg_shadow.pattern[$urandom_range(0, PAT_POS - 1)];
      return BYTE_W'($urandom);
   endfunction

   task automatic random_region();
      logic [BYTE_W-1:0] region_q [$];
      int unsigned       len;
      int unsigned       start;
      int unsigned       pick;
      len = active_len();
      repeat ($urandom_range(0, 12)) region_q.push_back(filler_byte());
      start = region_q.size();
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
         for (int i = 0; i < len; i++)
            region_q.push_back(cfg_shadow.care_mask[i] ? cfg_shadow.pattern[i]
                                                       : BYTE_W'($urandom));
         // broken copy: flip bits in one position
         if (pick >= 6) begin
            pick = start + $urandom_range(0, len - 1);
            region_q[pick] = region_q[pick] ^ BYTE_W'($urandom_range(1, 255));
         end
      end
      repeat ($urandom_range(0, 6)) region_q.push_back(filler_byte());
      if (region_q.size() == 0) region_q.push_back(filler_byte());
      send_region(region_q);
   endtask

   task automatic test_random_traffic();
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent < TOTAL_ITEMS - CALM_ITEMS) begin
            send_jitter = $urandom_range(0, 3) != 0;
            recv_jitter = $urandom_range(0, 3) != 0;
         end else begin
            send_jitter = 1'b0;
            recv_jitter = 1'b0;
         end
         random_config();
         repeat ($urandom_range(1, 6)) random_region();
         wait_idle();
      end
   endtask

   initial begin
      cfg_shadow = '0;
      cfg_shadow.pattern_length = 1;
      clear_scan();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      send_jitter = 1'b1;
      recv_jitter = 1'b1;
      test_leading_wildcard();
      test_address_wrap();
      test_length_clamp();
      test_unused_index();
      test_random_traffic();
      wait_idle();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> wildcard_byte_pattern_scanner_unit.f
+incdir+hw/rtl
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_csr.sv
hw/rtl/wbps_scan.sv
hw/rtl/wildcard_byte_pattern_scanner_unit.sv
sim/tb.sv
